// ----- rtl/core/breath_alcohol_gate_decider_defines.svh -----
// assertion macros for the decision stage of the breath alcohol gate decider rtl
`ifndef BREATH_ALCOHOL_GATE_DECIDER_DEFINES_SVH
`define BREATH_ALCOHOL_GATE_DECIDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BAGD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bagd check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BAGD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bagd check failed");

`endif

// ----- rtl/core/bagd_pkg.sv -----
// shared types, widths and reset constants for the breath alcohol gate decider
package bagd_pkg;

	localparam int RD_W       = 16;
	localparam int CNT_W      = 8;
	localparam int FAN_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [RD_W-1:0]  CRITICAL_LEVEL_RST = 16'd2250;
	localparam logic [RD_W-1:0]  BREATH_RISE_RST    = 16'd40;
	localparam logic [CNT_W-1:0] RISE_CONFIRM_RST   = 8'd5;
	localparam logic [CNT_W-1:0] OPEN_DELAY_RST     = 8'd5;
	localparam logic [CNT_W-1:0] QUIET_LIMIT_RST    = 8'd15;
	localparam logic [FAN_W-1:0] FAN_ON_TIME_RST    = 16'd1500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRITICAL_LEVEL = 3'd0,
		REG_BREATH_RISE    = 3'd1,
		REG_RISE_CONFIRM   = 3'd2,
		REG_OPEN_DELAY     = 3'd3,
		REG_QUIET_LIMIT    = 3'd4,
		REG_FAN_ON_TIME    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [RD_W-1:0]  critical_level;
		logic [RD_W-1:0]  breath_rise_level;
		logic [CNT_W-1:0] rise_confirm_count;
		logic [CNT_W-1:0] open_delay_count;
		logic [CNT_W-1:0] quiet_limit;
		logic [FAN_W-1:0] fan_on_time;
	} cfg_t;

	typedef struct packed {
		logic [RD_W-1:0] reading_a;
		logic [RD_W-1:0] reading_b;
		logic [RD_W-1:0] reading_c;
		logic [RD_W-1:0] baseline_a;
		logic [RD_W-1:0] baseline_b;
		logic [RD_W-1:0] baseline_c;
	} sample_t;

	typedef struct packed {
		logic alarm_event;
		logic door_open_event;
		logic baseline_clear;
		logic breath_allowed;
		logic baseline_update;
		logic fan_on;
	} decision_t;

endpackage

// ----- rtl/core/bagd_if.sv -----
// valid/ready channel interfaces for samples and decisions
interface bagd_sample_if import bagd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bagd_decision_if import bagd_pkg::*; ();
	logic      valid;
	logic      ready;
	decision_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/breath_alcohol_gate_decider.sv -----
// breath alcohol gate decider top level: config registers, input stage, decision stage
// a sample is registered in the input stage, then its decision in the result register of the decision stage
// throughput: one sample per cycle while the receiver takes decisions, set by the state update in the decision stage
// while a finished decision waits, the input stage can still hold one more sample and then stalls
// reset: all flags and counters clear, ready lamp on, fan off, registers take their defaults
// reset is asynchronous and active low; no clearing pass is needed afterwards
module breath_alcohol_gate_decider import bagd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	bagd_sample_if.sink           sample,
	bagd_decision_if.source       decision,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t       cfg;
	logic       valid_s1;
	logic       take;
	sample_t    sample_s1;

	bagd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bagd_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_data   (sample.data),
		.in_ready  (sample.ready),
		.valid_s1  (valid_s1),
		.take      (take),
		.sample_s1 (sample_s1)
	);

	bagd_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.take      (take),
		.sample_s1 (sample_s1),
		.out_ready (decision.ready),
		.out_valid (decision.valid),
		.result_s2 (decision.data)
	);

endmodule

// ----- rtl/core/bagd_cfg.sv -----
// configuration register file with write-only port
module bagd_cfg import bagd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_level     <= CRITICAL_LEVEL_RST;
			cfg_q.breath_rise_level  <= BREATH_RISE_RST;
			cfg_q.rise_confirm_count <= RISE_CONFIRM_RST;
			cfg_q.open_delay_count   <= OPEN_DELAY_RST;
			cfg_q.quiet_limit        <= QUIET_LIMIT_RST;
			cfg_q.fan_on_time        <= FAN_ON_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_CRITICAL_LEVEL: cfg_q.critical_level     <= cfg_wdata[RD_W-1:0];
				REG_BREATH_RISE:    cfg_q.breath_rise_level  <= cfg_wdata[RD_W-1:0];
				REG_RISE_CONFIRM:   cfg_q.rise_confirm_count <= cfg_wdata[CNT_W-1:0];
				REG_OPEN_DELAY:     cfg_q.open_delay_count   <= cfg_wdata[CNT_W-1:0];
				REG_QUIET_LIMIT:    cfg_q.quiet_limit        <= cfg_wdata[CNT_W-1:0];
				REG_FAN_ON_TIME:    cfg_q.fan_on_time        <= cfg_wdata[FAN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/bagd_in_stage.sv -----
// input register stage for incoming samples
module bagd_in_stage import bagd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  sample_t in_data,
	output logic    in_ready,
	output logic    valid_s1,
	input  logic    take,
	output sample_t sample_s1
);

	// a slot opens when it is empty or its sample moves on this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_data;
		end
	end

endmodule

// ----- rtl/core/bagd_decide.sv -----
// decision state, next-state logic and result register
`include "breath_alcohol_gate_decider_defines.svh"

module bagd_decide import bagd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       valid_s1,
	output logic       take,
	input  sample_t    sample_s1,
	input  logic       out_ready,
	output logic       out_valid,
	output decision_t  result_s2
);

	logic             valid_s2;

	logic             critical_latched_q, breath_seen_q, door_pending_q, allow_flag_q;
	logic             fan_running_q;
	logic [CNT_W-1:0] rise_count_q, pending_count_q, quiet_count_q;
	logic [FAN_W-1:0] fan_timer_q;

	logic             critical_latched_n, breath_seen_n, door_pending_n, allow_flag_n;
	logic             fan_running_n;
	logic [CNT_W-1:0] rise_count_n, pending_count_n, quiet_count_n;
	logic [FAN_W-1:0] fan_timer_n;

	logic             crit, ua, ub, uc, breath;
	logic             alarm, door, fan_start, fan_mid;
	logic [FAN_W-1:0] timer_mid;
	logic [CNT_W-1:0] rise_inc, pend_inc, quiet_inc;

	assign take = valid_s1 && (!valid_s2 || out_ready);

	// rise counts only when the reading is strictly above its baseline by more than the level
	assign ua = (sample_s1.reading_a > sample_s1.baseline_a) &&
		((sample_s1.reading_a - sample_s1.baseline_a) > cfg.breath_rise_level);
	assign ub = (sample_s1.reading_b > sample_s1.baseline_b) &&
		((sample_s1.reading_b - sample_s1.baseline_b) > cfg.breath_rise_level);
	assign uc = (sample_s1.reading_c > sample_s1.baseline_c) &&
		((sample_s1.reading_c - sample_s1.baseline_c) > cfg.breath_rise_level);
	assign breath = (ua && ub) || (ub && uc) || (ua && uc);
	assign crit = (sample_s1.reading_a > cfg.critical_level) ||
		(sample_s1.reading_b > cfg.critical_level) ||
		(sample_s1.reading_c > cfg.critical_level);

	assign rise_inc  = rise_count_q + CNT_W'(1);
	assign pend_inc  = pending_count_q + CNT_W'(1);
	assign quiet_inc = quiet_count_q + CNT_W'(1);

	always_comb begin
		critical_latched_n = critical_latched_q;
		breath_seen_n      = breath_seen_q;
		door_pending_n     = door_pending_q;
		allow_flag_n       = allow_flag_q;
		rise_count_n       = rise_count_q;
		pending_count_n    = pending_count_q;
		quiet_count_n      = quiet_count_q;
		alarm              = 1'b0;
		door               = 1'b0;
		fan_start          = 1'b0;
		if (crit) begin
			fan_start      = 1'b1;
			quiet_count_n  = '0;
			door_pending_n = 1'b0;
			allow_flag_n   = 1'b0;
			if (!critical_latched_q) begin
				critical_latched_n = 1'b1;
				alarm              = 1'b1;
			end
		end else if (door_pending_q) begin
			pending_count_n = pend_inc;
			allow_flag_n    = 1'b0;
			if (pend_inc >= cfg.open_delay_count) begin
				fan_start       = 1'b1;
				door_pending_n  = 1'b0;
				pending_count_n = '0;
				door            = 1'b1;
			end
		end else if (breath) begin
			quiet_count_n = '0;
			if (!critical_latched_q) begin
				rise_count_n = rise_inc;
				if (rise_inc >= cfg.rise_confirm_count) begin
					allow_flag_n   = 1'b0;
					rise_count_n   = '0;
					door_pending_n = 1'b1;
				end
				breath_seen_n = 1'b1;
			end
		end else begin
			quiet_count_n = quiet_inc;
			if (quiet_inc >= cfg.quiet_limit) begin
				critical_latched_n = 1'b0;
				breath_seen_n      = 1'b0;
				quiet_count_n      = '0;
				rise_count_n       = '0;
				door_pending_n     = 1'b0;
				allow_flag_n       = 1'b1;
			end
		end
	end

	// a start step already counts as the first fan step
	assign fan_mid   = fan_start || fan_running_q;
	assign timer_mid = fan_start ? cfg.fan_on_time : fan_timer_q;

	always_comb begin
		fan_running_n = fan_running_q;
		fan_timer_n   = fan_timer_q;
		if (fan_mid) begin
			if (timer_mid <= FAN_W'(1)) begin
				fan_running_n = 1'b0;
				fan_timer_n   = '0;
			end else begin
				fan_running_n = 1'b1;
				fan_timer_n   = timer_mid - FAN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			critical_latched_q <= 1'b0;
			breath_seen_q      <= 1'b0;
			door_pending_q     <= 1'b0;
			allow_flag_q       <= 1'b1;
			rise_count_q       <= '0;
			pending_count_q    <= '0;
			quiet_count_q      <= '0;
			fan_running_q      <= 1'b0;
			fan_timer_q        <= '0;
		end else if (take) begin
			critical_latched_q <= critical_latched_n;
			breath_seen_q      <= breath_seen_n;
			door_pending_q     <= door_pending_n;
			allow_flag_q       <= allow_flag_n;
			rise_count_q       <= rise_count_n;
			pending_count_q    <= pending_count_n;
			quiet_count_q      <= quiet_count_n;
			fan_running_q      <= fan_running_n;
			fan_timer_q        <= fan_timer_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_s2.alarm_event     <= alarm;
			result_s2.door_open_event <= door;
			result_s2.baseline_clear  <= door;
			result_s2.breath_allowed  <= allow_flag_n;
			result_s2.baseline_update <= !(breath_seen_n || critical_latched_n);
			result_s2.fan_on          <= fan_running_n;
		end
	end

	assign out_valid = valid_s2;

	// state only moves with the result register, so a held result matches the state
	`BAGD_ASSERT_SAME(a_alarm_latched, valid_s2 && result_s2.alarm_event, critical_latched_q)
	`BAGD_ASSERT_SAME(a_update_matches, valid_s2,
		result_s2.baseline_update == !(breath_seen_q || critical_latched_q))
	`BAGD_ASSERT_SAME(a_fan_timer_idle, !fan_running_q, fan_timer_q == '0)
	`BAGD_ASSERT_NEXT(a_crit_blocks, take && crit, critical_latched_q && !allow_flag_q)

endmodule

// ----- tb/bagd_decision_checker.sv -----
// scoreboard for the breath alcohol gate decider: mirrors the registers, predicts and compares decisions
module bagd_decision_checker import bagd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_ready,
	input  sample_t               sample_data,
	input  logic                  decision_valid,
	input  logic                  decision_ready,
	input  decision_t             decision_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    decisions_waiting,
	output int                    decisions_checked,
	output int                    doors_seen,
	output int                    alarms_seen
);

	cfg_t             cfg;
	logic             alarm_latched;
	logic             breath_flag;
	logic [CNT_W-1:0] breath_steps;
	logic             door_armed;
	logic [CNT_W-1:0] armed_steps;
	logic [CNT_W-1:0] quiet_steps;
	logic             lamp_on;
	logic             fan_active;
	logic [FAN_W-1:0] fan_left;

	decision_t expected_decisions[$];
	int        errors  = 0;
	int        checked = 0;
	int        doors   = 0;
	int        alarms  = 0;

	task automatic reset_model();
		cfg = '{CRITICAL_LEVEL_RST, BREATH_RISE_RST, RISE_CONFIRM_RST,
			OPEN_DELAY_RST, QUIET_LIMIT_RST, FAN_ON_TIME_RST};
		alarm_latched = 1'b0;
		breath_flag   = 1'b0;
		breath_steps  = '0;
		door_armed    = 1'b0;
		armed_steps   = '0;
		quiet_steps   = '0;
		lamp_on       = 1'b1;
		fan_active    = 1'b0;
		fan_left      = '0;
	endtask

	task automatic mirror_write();
		case (cfg_idx)
			REG_CRITICAL_LEVEL: cfg.critical_level     = cfg_wdata;
			REG_BREATH_RISE:    cfg.breath_rise_level  = cfg_wdata;
			REG_RISE_CONFIRM:   cfg.rise_confirm_count = cfg_wdata[CNT_W-1:0];
			REG_OPEN_DELAY:     cfg.open_delay_count   = cfg_wdata[CNT_W-1:0];
			REG_QUIET_LIMIT:    cfg.quiet_limit        = cfg_wdata[CNT_W-1:0];
			REG_FAN_ON_TIME:    cfg.fan_on_time        = cfg_wdata;
			default: ;
		endcase
	endtask

	// a baseline above the reading gives a negative rise, never a breath
	function automatic logic rises_over(input logic [RD_W-1:0] rd, input logic [RD_W-1:0] base);
		int diff;
		diff = int'(rd) - int'(base);
		return diff > int'(cfg.breath_rise_level);
	endfunction

	function automatic void fan_kick();
		fan_active = 1'b1;
		fan_left   = cfg.fan_on_time;
	endfunction

	function automatic decision_t next_decision(input sample_t s);
		decision_t d;
		logic      ua;
		logic      ub;
		logic      uc;
		d  = '0;
		ua = rises_over(s.reading_a, s.baseline_a);
		ub = rises_over(s.reading_b, s.baseline_b);
		uc = rises_over(s.reading_c, s.baseline_c);
		if (s.reading_a > cfg.critical_level || s.reading_b > cfg.critical_level ||
			s.reading_c > cfg.critical_level) begin
			fan_kick();
			quiet_steps = '0;
			door_armed  = 1'b0;
			lamp_on     = 1'b0;
			if (!alarm_latched) begin
				alarm_latched = 1'b1;
				d.alarm_event = 1'b1;
			end
		end else if (door_armed) begin
			armed_steps = armed_steps + 8'd1;
			lamp_on     = 1'b0;
			if (armed_steps >= cfg.open_delay_count) begin
				fan_kick();
				door_armed        = 1'b0;
				armed_steps       = '0;
				d.door_open_event = 1'b1;
				d.baseline_clear  = 1'b1;
			end
		end else if ((ua && ub) || (ub && uc) || (ua && uc)) begin
			quiet_steps = '0;
			if (!alarm_latched) begin
				breath_steps = breath_steps + 8'd1;
				if (breath_steps >= cfg.rise_confirm_count) begin
					lamp_on      = 1'b0;
					breath_steps = '0;
					door_armed   = 1'b1;
				end
				breath_flag = 1'b1;
			end
		end else begin
			quiet_steps = quiet_steps + 8'd1;
			if (quiet_steps >= cfg.quiet_limit) begin
				alarm_latched = 1'b0;
				breath_flag   = 1'b0;
				quiet_steps   = '0;
				breath_steps  = '0;
				door_armed    = 1'b0;
				lamp_on       = 1'b1;
			end
		end
		if (fan_active) begin
			if (fan_left <= 16'd1) begin
				fan_active = 1'b0;
				fan_left   = '0;
			end else begin
				fan_left = fan_left - 16'd1;
			end
		end
		d.breath_allowed  = lamp_on;
		d.baseline_update = !breath_flag && !alarm_latched;
		d.fan_on          = fan_active;
		return d;
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= 40)
			$display("[%0t] decision %0d: %s", $time, checked, msg);
	endtask

	task automatic check_field(input string name, input logic got, input logic want);
		if (got !== want)
			report($sformatf("%s got %b want %b", name, got, want));
	endtask

	task automatic compare_decision(input decision_t got);
		decision_t want;
		if (expected_decisions.size() == 0) begin
			report("decision transaction with no sample outstanding");
		end else begin
			want = expected_decisions.pop_front();
			check_field("alarm_event", got.alarm_event, want.alarm_event);
			check_field("door_open_event", got.door_open_event, want.door_open_event);
			check_field("baseline_clear", got.baseline_clear, want.baseline_clear);
			check_field("breath_allowed", got.breath_allowed, want.breath_allowed);
			check_field("baseline_update", got.baseline_update, want.baseline_update);
			check_field("fan_on", got.fan_on, want.fan_on);
		end
		checked++;
		if (got.door_open_event === 1'b1)
			doors++;
		if (got.alarm_event === 1'b1)
			alarms++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			expected_decisions.delete();
		end else begin
			if (cfg_we)
				mirror_write();
			if (sample_valid && sample_ready)
				expected_decisions.push_back(next_decision(sample_data));
			if (decision_valid && decision_ready)
				compare_decision(decision_data);
		end
		fail_count        <= errors;
		decisions_waiting <= expected_decisions.size();
		decisions_checked <= checked;
		doors_seen        <= doors;
		alarms_seen       <= alarms;
	end

endmodule

// ----- tb/tb_breath_alcohol_gate_decider.sv -----
// stimulus, register settings and verdict for the breath alcohol gate decider regression
module tb_breath_alcohol_gate_decider;
	import bagd_pkg::*;

	localparam int     RUN_ITEMS    = 1900;
	localparam int     PHASES       = 9;
	localparam int     DRAIN_CYCLES = 6;
	localparam longint CYCLE_LIMIT  = 600000;

	typedef enum int {RUN_QUIET, RUN_BREATH, RUN_CRITICAL, RUN_NOISE} run_kind_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bagd_sample_if   sample_ch();
	bagd_decision_if decision_ch();

	int          fail_count;
	int          decisions_waiting;
	int          decisions_checked;
	int          doors_seen;
	int          alarms_seen;
	longint      cycles       = 0;
	int          samples_sent = 0;
	cfg_t        cur_cfg;
	sample_t     stim_q[$];
	stall_mode_t stall_mode   = STALL_NONE;
	int          stall_left   = 0;

	breath_alcohol_gate_decider dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.decision (decision_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	bagd_decision_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_valid     (sample_ch.valid),
		.sample_ready     (sample_ch.ready),
		.sample_data      (sample_ch.data),
		.decision_valid   (decision_ch.valid),
		.decision_ready   (decision_ch.ready),
		.decision_data    (decision_ch.data),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.fail_count       (fail_count),
		.decisions_waiting(decisions_waiting),
		.decisions_checked(decisions_checked),
		.doors_seen       (doors_seen),
		.alarms_seen      (alarms_seen)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stalls in stretches, each with its own flavor
	always @(posedge clk) begin
		if (!arst_n) begin
			decision_ch.ready <= 1'b0;
			stall_left        <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_left <= $urandom_range(8, 80);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				STALL_NONE:  decision_ch.ready <= 1'b1;
				STALL_LIGHT: decision_ch.ready <= ($urandom_range(0, 3) != 0);
				STALL_HEAVY: decision_ch.ready <= ($urandom_range(0, 9) < 3);
				default:     decision_ch.ready <= (stall_left % 3 != 0);
			endcase
		end
	end

	// reading at or below critical, rise at or below the breath level
	function automatic void quiet_pair(output logic [RD_W-1:0] r, output logic [RD_W-1:0] b);
		r = RD_W'($urandom_range(0, cur_cfg.critical_level));
		if (r > cur_cfg.breath_rise_level)
			b = RD_W'($urandom_range(r - cur_cfg.breath_rise_level, 16'hFFFF));
		else
			b = RD_W'($urandom);
	endfunction

	function automatic void rise_pair(output logic [RD_W-1:0] r, output logic [RD_W-1:0] b);
		if (cur_cfg.critical_level > cur_cfg.breath_rise_level) begin
			r = RD_W'($urandom_range(cur_cfg.breath_rise_level + 1, cur_cfg.critical_level));
			b = RD_W'($urandom_range(0, r - cur_cfg.breath_rise_level - 1));
		end else begin
			quiet_pair(r, b);
		end
	endfunction

	function automatic logic [RD_W-1:0] critical_reading();
		if (cur_cfg.critical_level == 16'hFFFF)
			critical_reading = 16'hFFFF;
		else
			critical_reading = RD_W'($urandom_range(cur_cfg.critical_level + 1, 16'hFFFF));
	endfunction

	function automatic sample_t make_sample(input run_kind_t kind);
		logic [RD_W-1:0] r [3];
		logic [RD_W-1:0] b [3];
		logic [2:0]      mask;
		int              sel;
		case (kind)
			RUN_BREATH: begin
				sel = $urandom_range(0, 3);
				mask = (sel == 0) ? 3'b011 : (sel == 1) ? 3'b110 : (sel == 2) ? 3'b101 : 3'b111;
				for (int i = 0; i < 3; i++)
					if (mask[i]) rise_pair(r[i], b[i]);
					else quiet_pair(r[i], b[i]);
			end
			RUN_CRITICAL: begin
				mask = 3'($urandom_range(1, 7));
				for (int i = 0; i < 3; i++) begin
					if (mask[i]) begin
						r[i] = critical_reading();
						b[i] = RD_W'($urandom);
					end else if ($urandom_range(0, 1) == 0) begin
						rise_pair(r[i], b[i]);
					end else begin
						quiet_pair(r[i], b[i]);
					end
				end
			end
			RUN_NOISE: begin
				for (int i = 0; i < 3; i++) begin
					r[i] = RD_W'($urandom);
					b[i] = RD_W'($urandom);
				end
			end
			default: begin
				// a lone rising sensor is still a quiet step
				sel = $urandom_range(0, 5);
				for (int i = 0; i < 3; i++)
					if (i == sel) rise_pair(r[i], b[i]);
					else quiet_pair(r[i], b[i]);
			end
		endcase
		return '{r[0], r[1], r[2], b[0], b[1], b[2]};
	endfunction

	function automatic sample_t mk(input logic [RD_W-1:0] ra, input logic [RD_W-1:0] rb,
		input logic [RD_W-1:0] rc, input logic [RD_W-1:0] ba, input logic [RD_W-1:0] bb,
		input logic [RD_W-1:0] bc);
		return '{ra, rb, rc, ba, bb, bc};
	endfunction

	// written for critical 2250, rise 40, confirm 2, open delay 2, quiet 3, fan 4
	task automatic queue_directed();
		stim_q.push_back(mk(0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(2250, 2250, 2250, 2210, 2210, 2210)); // rise exactly at level
		stim_q.push_back(mk(2250, 2250, 0, 2209, 2209, 0));
		stim_q.push_back(mk(0, 2250, 2250, 0, 2209, 2209));       // becomes candidate
		stim_q.push_back(mk(0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(2250, 2250, 2250, 16'hFFFF, 16'hFFFF, 16'hFFFF)); // door opens
		stim_q.push_back(mk(2250, 0, 2250, 0, 0, 0));
		stim_q.push_back(mk(100, 100, 100, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		stim_q.push_back(mk(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		stim_q.push_back(mk(0, 0, 0, 0, 0, 0));                   // quiet run clears
		stim_q.push_back(mk(2251, 0, 0, 0, 0, 0));                // alarm latches
		stim_q.push_back(mk(0, 2251, 0, 0, 0, 0));
		stim_q.push_back(mk(0, 0, 2251, 0, 0, 0));
		stim_q.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
		stim_q.push_back(mk(2250, 2250, 2250, 0, 0, 0));          // breath while latched
		repeat (3) stim_q.push_back(mk(0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(2250, 2250, 2250, 0, 0, 0));
		stim_q.push_back(mk(2250, 2250, 2250, 0, 0, 0));
		stim_q.push_back(mk(0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(2251, 0, 0, 0, 0, 0));                // critical drops the candidate
		stim_q.push_back(mk(1000, 1000, 1000, 0, 0, 0));
	endtask

	task automatic queue_random(input int n);
		int        done;
		int        len;
		int        pick;
		run_kind_t kind;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				kind = RUN_BREATH;
				len  = $urandom_range(1, cur_cfg.rise_confirm_count + cur_cfg.open_delay_count + 3);
			end else if (pick < 75) begin
				kind = RUN_QUIET;
				len  = $urandom_range(1, cur_cfg.quiet_limit + 2);
			end else if (pick < 85) begin
				kind = RUN_CRITICAL;
				len  = $urandom_range(1, 3);
			end else begin
				kind = RUN_NOISE;
				len  = $urandom_range(1, 4);
			end
			repeat (len) stim_q.push_back(make_sample(kind));
			done += len;
		end
	endtask

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.critical_level     = RD_W'($urandom_range(400, 5000));
		c.breath_rise_level  = RD_W'($urandom_range(0, 350));
		c.rise_confirm_count = CNT_W'($urandom_range(1, 6));
		c.open_delay_count   = CNT_W'($urandom_range(1, 6));
		c.quiet_limit        = CNT_W'($urandom_range(1, 20));
		c.fan_on_time        = FAN_W'($urandom_range(1, 40));
		return c;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic apply_settings(input cfg_t c);
		write_reg(REG_CRITICAL_LEVEL, c.critical_level);
		write_reg(REG_BREATH_RISE, c.breath_rise_level);
		write_reg(REG_RISE_CONFIRM, CFG_DATA_W'(c.rise_confirm_count));
		write_reg(REG_OPEN_DELAY, CFG_DATA_W'(c.open_delay_count));
		write_reg(REG_QUIET_LIMIT, CFG_DATA_W'(c.quiet_limit));
		write_reg(REG_FAN_ON_TIME, c.fan_on_time);
		cfg_we  <= 1'b0;
		cur_cfg = c;
	endtask

	// sender works in bursts; valid stays up across a burst boundary with no gap
	task automatic drive_samples();
		int burst;
		int gap;
		while (stim_q.size() > 0) begin
			burst = $urandom_range(1, 30);
			while (burst > 0 && stim_q.size() > 0) begin
				sample_ch.valid <= 1'b1;
				sample_ch.data  <= stim_q.pop_front();
				do @(posedge clk); while (!sample_ch.ready);
				samples_sent++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		sample_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (decisions_waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		cfg_t phase_cfg [PHASES];
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = REG_CRITICAL_LEVEL;
		cfg_wdata         = '0;
		sample_ch.valid   = 1'b0;
		sample_ch.data    = '0;

		phase_cfg[0] = '{16'd2250, 16'd40, 8'd2, 8'd2, 8'd3, 16'd4};
		phase_cfg[1] = '{CRITICAL_LEVEL_RST, BREATH_RISE_RST, RISE_CONFIRM_RST,
			OPEN_DELAY_RST, QUIET_LIMIT_RST, FAN_ON_TIME_RST};
		phase_cfg[2] = '{16'd2250, 16'd0, 8'd1, 8'd1, 8'd1, 16'd1};
		phase_cfg[3] = '{16'hFFFF, 16'd300, 8'd255, 8'd255, 8'd255, 16'hFFFF};
		phase_cfg[4] = '{16'd0, 16'hFFFF, 8'd3, 8'd3, 8'd4, 16'd2};
		for (int p = 5; p < PHASES; p++)
			phase_cfg[p] = rand_cfg();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				wait_idle();
			apply_settings(phase_cfg[p]);
			if (p == 0)
				queue_directed();
			else
				queue_random(RUN_ITEMS / (PHASES - 1));
			drive_samples();
		end
		wait_idle();

		$display("sent %0d samples across %0d register settings, %0d decisions checked",
			samples_sent, PHASES, decisions_checked);
		$display("doors opened %0d times, alarms latched %0d times", doors_seen, alarms_seen);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
